// File: sv/gbs_pkg.sv
// Shared types, constants and helper functions for the GIF block scanner.
`timescale 1ns / 1ps
`default_nettype none

package gbs_pkg;

  localparam int COUNT_BITS_DEFAULT = 16;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [15:0] MAX_DELAY_RESET = 16'hFFFF;

  localparam logic [7:0] TRAILER_BYTE = 8'h3B;
  localparam logic [7:0] EXT_INTRODUCER = 8'h21;
  localparam logic [7:0] GCE_LABEL = 8'hF9;
  localparam logic [7:0] IMAGE_SEPARATOR = 8'h2C;
  localparam int TABLE_FLAG_BIT = 7;

  localparam logic [3:0] HEADER_LAST_POS = 4'd12;
  localparam logic [3:0] HEADER_FLAGS_POS = 4'd10;
  localparam logic [3:0] SIGNATURE_LEN = 4'd3;
  localparam logic [3:0] DESC_LAST_POS = 4'd8;

  localparam logic [2:0] GCE_DELAY_LOW_POS = 3'd3;
  localparam logic [2:0] GCE_DELAY_HIGH_POS = 3'd4;

  localparam logic REC_DELAY = 1'b0;
  localparam logic REC_SUMMARY = 1'b1;

  typedef enum logic [3:0] {
    PH_HEADER    = 4'd0,
    PH_GCT       = 4'd1,
    PH_BLOCK     = 4'd2,
    PH_EXT_LABEL = 4'd3,
    PH_EXT_SIZE  = 4'd4,
    PH_EXT_DATA  = 4'd5,
    PH_DESC      = 4'd6,
    PH_LCT       = 4'd7,
    PH_LZW       = 4'd8,
    PH_IMG_SIZE  = 4'd9,
    PH_IMG_DATA  = 4'd10,
    PH_DONE      = 4'd11
  } phase_t;

  typedef struct packed {
    logic        has_frame;
    logic [15:0] frame_index;
    logic [15:0] delay_cs;
    logic        has_summary;
    logic [15:0] frame_count;
    logic        status;
  } event_t;

  function automatic logic [7:0] signature_byte(input logic [1:0] pos);
    logic [7:0] value;
    unique case (pos)
      2'd0: value = 8'h47;
      2'd1: value = 8'h49;
      default: value = 8'h46;
    endcase
    return value;
  endfunction

  function automatic logic [9:0] table_bytes(input logic [7:0] flags);
    logic [9:0] entries;
    entries = 10'd2 << flags[2:0];
    return entries + (entries << 1);
  endfunction

endpackage

`default_nettype wire

// File: sv/gbs_front.sv
// Front end: accepts GIF bytes, tracks the block structure and emits record events.
`timescale 1ns / 1ps
`default_nettype none

module gbs_front
  import gbs_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  byte_value,
  input  wire logic        end_of_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data,
  output logic             ev_push,
  output event_t           ev,
  input  wire logic        ev_full
);

  localparam int CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [15:0]           max_delay_records;
  phase_t                phase, phase_next;
  logic [9:0]            skip, skip_next;
  logic [3:0]            hpos, hpos_next;
  logic [7:0]            flags, flags_next;
  logic [2:0]            cpos, cpos_next;
  logic [7:0]            dlow, dlow_next;
  logic [15:0]           pend, pend_next;
  logic [COUNT_BITS-1:0] frames, frames_next;

  logic    accept;
  logic    fail;
  logic    trailer;
  logic    finish;
  logic [CW-1:0] frames_w;
  logic [CW-1:0] max_w;
  event_t  ev_comb;

  assign full = ev_full;
  assign cfg_ready = 1'b1;
  assign accept = push && !ev_full;
  assign frames_w = CW'(frames);
  assign max_w = CW'(max_delay_records);

  always_comb begin
    phase_next = phase;
    skip_next = skip;
    hpos_next = hpos;
    flags_next = flags;
    cpos_next = cpos;
    dlow_next = dlow;
    pend_next = pend;
    frames_next = frames;
    fail = 1'b0;
    trailer = 1'b0;
    finish = 1'b0;
    ev_comb = '0;

    // The delay bytes are counted in raw stream bytes after the label.
    if (cpos != 3'd0 && phase != PH_DONE) begin
      if (cpos == GCE_DELAY_LOW_POS) begin
        dlow_next = byte_value;
        cpos_next = cpos + 3'd1;
      end else if (cpos >= GCE_DELAY_HIGH_POS) begin
        pend_next = {byte_value, dlow};
        cpos_next = 3'd0;
      end else begin
        cpos_next = cpos + 3'd1;
      end
    end

    unique case (phase)
      PH_HEADER: begin
        if (hpos < SIGNATURE_LEN && byte_value != signature_byte(hpos[1:0])) begin
          fail = 1'b1;
        end else if (hpos >= HEADER_LAST_POS) begin
          if (flags[TABLE_FLAG_BIT]) begin
            skip_next = table_bytes(flags);
            phase_next = PH_GCT;
          end else begin
            phase_next = PH_BLOCK;
          end
        end else begin
          if (hpos == HEADER_FLAGS_POS) begin
            flags_next = byte_value;
          end
          hpos_next = hpos + 4'd1;
        end
      end
      PH_GCT, PH_LCT: begin
        skip_next = skip - 10'd1;
        if (skip_next == 10'd0) begin
          phase_next = (phase == PH_GCT) ? PH_BLOCK : PH_LZW;
        end
      end
      PH_BLOCK: begin
        priority if (byte_value == TRAILER_BYTE) begin
          trailer = 1'b1;
        end else if (byte_value == EXT_INTRODUCER) begin
          phase_next = PH_EXT_LABEL;
        end else if (byte_value == IMAGE_SEPARATOR) begin
          hpos_next = 4'd0;
          phase_next = PH_DESC;
        end else begin
          fail = 1'b1;
        end
      end
      PH_EXT_LABEL: begin
        if (byte_value == GCE_LABEL) begin
          cpos_next = 3'd1;
        end
        phase_next = PH_EXT_SIZE;
      end
      PH_EXT_SIZE, PH_IMG_SIZE: begin
        if (byte_value == 8'd0) begin
          finish = (phase == PH_IMG_SIZE);
          phase_next = PH_BLOCK;
        end else begin
          skip_next = {2'b00, byte_value};
          phase_next = (phase == PH_IMG_SIZE) ? PH_IMG_DATA : PH_EXT_DATA;
        end
      end
      PH_EXT_DATA, PH_IMG_DATA: begin
        skip_next = skip - 10'd1;
        if (skip_next == 10'd0) begin
          phase_next = (phase == PH_IMG_DATA) ? PH_IMG_SIZE : PH_EXT_SIZE;
        end
      end
      PH_DESC: begin
        if (hpos >= DESC_LAST_POS) begin
          flags_next = byte_value;
          if (byte_value[TABLE_FLAG_BIT]) begin
            skip_next = table_bytes(byte_value);
            phase_next = PH_LCT;
          end else begin
            phase_next = PH_LZW;
          end
        end else begin
          hpos_next = hpos + 4'd1;
        end
      end
      PH_LZW: begin
        phase_next = PH_IMG_SIZE;
      end
      default: begin
        phase_next = PH_DONE;
      end
    endcase

    if (!fail && !trailer && end_of_data) begin
      unique case (phase_next)
        PH_IMG_SIZE, PH_IMG_DATA: begin
          finish = 1'b1;
          trailer = 1'b1;
        end
        PH_BLOCK, PH_EXT_SIZE, PH_EXT_DATA: begin
          trailer = 1'b1;
        end
        PH_DONE: begin
        end
        default: begin
          fail = 1'b1;
        end
      endcase
    end

    if (finish) begin
      ev_comb.has_frame = (frames_w < max_w);
      ev_comb.frame_index = frames_w[15:0];
      ev_comb.delay_cs = pend_next;
      if (frames != COUNT_MAX) begin
        frames_next = frames + 1'b1;
      end
      pend_next = 16'd0;
    end

    if (fail || trailer) begin
      ev_comb.has_summary = 1'b1;
      ev_comb.frame_count = 16'(frames_next);
      ev_comb.status = fail;
      phase_next = PH_DONE;
    end

    if (end_of_data) begin
      phase_next = PH_HEADER;
      skip_next = 10'd0;
      hpos_next = 4'd0;
      flags_next = 8'd0;
      cpos_next = 3'd0;
      dlow_next = 8'd0;
      pend_next = 16'd0;
      frames_next = '0;
    end
  end

  assign ev = ev_comb;
  assign ev_push = accept && (ev_comb.has_frame || ev_comb.has_summary);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_delay_records <= MAX_DELAY_RESET;
      phase <= PH_HEADER;
      skip <= 10'd0;
      hpos <= 4'd0;
      flags <= 8'd0;
      cpos <= 3'd0;
      dlow <= 8'd0;
      pend <= 16'd0;
      frames <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_delay_records <= cfg_data;
      end
      if (accept) begin
        phase <= phase_next;
        skip <= skip_next;
        hpos <= hpos_next;
        flags <= flags_next;
        cpos <= cpos_next;
        dlow <= dlow_next;
        pend <= pend_next;
        frames <= frames_next;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/gbs_queue.sv
// Short event queue between the parser front end and the record back end.
`timescale 1ns / 1ps
`default_nettype none

module gbs_queue
  import gbs_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire event_t push_data,
  output logic        full,
  output event_t      head,
  output logic        empty,
  input  wire logic   pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

  event_t          slots [DEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [CNTW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full = (count == CNTW'(DEPTH));
  assign empty = (count == '0);
  assign head = slots[rptr];
  assign do_push = push && !full;
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == LAST_SLOT) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == LAST_SLOT) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/gbs_back.sv
// Back end: expands queued events into delay and summary records in an output register.
`timescale 1ns / 1ps
`default_nettype none

module gbs_back
  import gbs_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire event_t head,
  input  wire logic   q_empty,
  output logic        q_pop,
  output logic        empty,
  input  wire logic   pop,
  output logic        record_kind,
  output logic [15:0] frame_index,
  output logic [19:0] frame_delay,
  output logic [15:0] frame_count,
  output logic        status,
  output logic        last_of_run
);

  logic        out_valid;
  logic        second;
  logic        load;
  logic        take;
  logic        emit_frame;
  logic [19:0] delay_wide;

  assign empty = !out_valid;
  assign load = !out_valid || pop;
  assign take = load && !q_empty;
  assign emit_frame = head.has_frame && !second;
  assign q_pop = take && (!emit_frame || !head.has_summary);
  assign delay_wide = {4'd0, head.delay_cs};

  always_ff @(posedge clk) begin
    if (take) begin
      if (emit_frame) begin
        record_kind <= REC_DELAY;
        frame_index <= head.frame_index;
        frame_delay <= (delay_wide << 3) + (delay_wide << 1);
        frame_count <= 16'd0;
        status <= 1'b0;
        last_of_run <= !head.has_summary;
      end else begin
        record_kind <= REC_SUMMARY;
        frame_index <= 16'd0;
        frame_delay <= 20'd0;
        frame_count <= head.frame_count;
        status <= head.status;
        last_of_run <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= !q_empty;
      end
      if (take) begin
        second <= emit_frame && head.has_summary;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/gif_block_scanner.sv
// Top level of the GIF block scanner: parser front end, event queue and record back end.
//
//   Channel  Handshake             Payload
//   input    push / full           byte_value, end_of_data
//   config   cfg_valid / cfg_ready cfg_data (max_delay_records)
//   result   empty / pop           record_kind, frame_index, frame_delay, frame_count,
//                                  status, last_of_run
//
// One byte is taken per cycle while the event queue has room; the parser updates its
// phase and down-counter in that same cycle. A byte that causes records puts one event
// in the queue, and the back end turns it into one or two records, one per cycle
// while pop is held high. Each event is written into the queue, and its first record is
// loaded into the output register that drives the result ports. Reset is synchronous;
// no clearing pass follows. A stalled result side fills the queue and then raises full.
`timescale 1ns / 1ps
`default_nettype none

module gif_block_scanner
  import gbs_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  byte_value,
  input  wire logic        end_of_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data,
  output logic             empty,
  input  wire logic        pop,
  output logic             record_kind,
  output logic [15:0]      frame_index,
  output logic [19:0]      frame_delay,
  output logic [15:0]      frame_count,
  output logic             status,
  output logic             last_of_run
);

  event_t ev;
  logic   ev_push;
  logic   ev_full;
  event_t head;
  logic   q_empty;
  logic   q_pop;

  gbs_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .byte_value(byte_value),
    .end_of_data(end_of_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .ev_push(ev_push),
    .ev(ev),
    .ev_full(ev_full)
  );

  gbs_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(ev_push),
    .push_data(ev),
    .full(ev_full),
    .head(head),
    .empty(q_empty),
    .pop(q_pop)
  );

  gbs_back u_back (
    .clk(clk),
    .rst(rst),
    .head(head),
    .q_empty(q_empty),
    .q_pop(q_pop),
    .empty(empty),
    .pop(pop),
    .record_kind(record_kind),
    .frame_index(frame_index),
    .frame_delay(frame_delay),
    .frame_count(frame_count),
    .status(status),
    .last_of_run(last_of_run)
  );

  a_summary_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && record_kind == REC_SUMMARY) |-> last_of_run)
    else $error("summary record without last_of_run");

  a_delay_fields_clear: assert property (@(posedge clk) disable iff (rst)
    (!empty && record_kind == REC_DELAY) |-> (frame_count == 16'd0 && !status))
    else $error("delay record carries summary fields");

  a_summary_follows: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !last_of_run) |=> (!empty && record_kind == REC_SUMMARY))
    else $error("summary did not follow its delay record");

  a_no_empty_event: assert property (@(posedge clk) disable iff (rst)
    ev_push |-> (ev.has_frame || ev.has_summary))
    else $error("event without records entered the queue");

endmodule

`default_nettype wire
